### rtl/core/omfsne_pkg.sv
package omfsne_pkg;

    // Record types.
    localparam logic [7:0] REC_THEADR = 8'h80;
    localparam logic [7:0] REC_COMENT = 8'h88;

    // Comment classes that carry names.
    localparam logic [7:0] CLASS_DEP_LIST     = 8'hE9;
    localparam logic [7:0] CLASS_DEP_LIST_ALT = 8'hFB;
    localparam logic [7:0] CLASS_DEP_FILE     = 8'h88;
    localparam logic [7:0] CLASS_SRC_FILE     = 8'hE8;

    // Smallest record lengths for each layout.
    localparam logic [15:0] MIN_LEN_COMENT    = 16'd2;
    localparam logic [15:0] MIN_LEN_DEP_LIST  = 16'd6;
    localparam logic [15:0] MIN_LEN_DEP_FILE  = 16'd7;
    localparam logic [15:0] MIN_LEN_SRC_FILE  = 16'd3;

    // Offset of the last timestamp byte inside a comment record.
    localparam logic [15:0] STAMP_LAST_OFFSET = 16'd5;

    typedef enum logic [3:0] {
        PH_TYPE     = 4'd0,
        PH_LEN_LO   = 4'd1,
        PH_LEN_HI   = 4'd2,
        PH_SKIP     = 4'd3,
        PH_HDR_LEN  = 4'd4,
        PH_CM_TYPE  = 4'd5,
        PH_CM_CLASS = 4'd6,
        PH_STAMP    = 4'd7,
        PH_LIST_LEN = 4'd8,
        PH_NAME     = 4'd9,
        PH_ONE_LEN  = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        ORIGIN_HEADER   = 2'd0,
        ORIGIN_DEP_LIST = 2'd1,
        ORIGIN_DEP_FILE = 2'd2,
        ORIGIN_SRC_FILE = 2'd3
    } origin_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_valid;
        logic       name_last;
        origin_t    name_origin;
        logic       finished;
        logic       found_any;
    } result_t;

endpackage

### rtl/core/omfsne_parser.sv
module omfsne_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic [7:0]            data_byte,
    input  logic                  first_byte,
    input  logic [31:0]           stream_length,
    output omfsne_pkg::result_t   result
);

    logic [31:0]          pos_reg, pos_next, pos_cur;
    omfsne_pkg::phase_t   phase_reg, phase_next, phase_cur;
    logic [7:0]           kind_reg, kind_next, kind_cur;
    logic [15:0]          len_reg, len_next, len_cur;
    logic [15:0]          off_reg, off_next, off_cur;
    logic [7:0]           class_reg, class_next, class_cur;
    logic [7:0]           rem_reg, rem_next, rem_cur;
    logic                 any_reg, any_next, any_cur;
    logic                 stop_reg, stop_next, stop_cur;

    logic                 in_file;
    logic                 active;
    logic                 emit;
    logic [15:0]          len_full;
    logic [16:0]          name_end;
    logic [16:0]          off_inc;
    omfsne_pkg::origin_t  origin;

    // A first byte starts the file over before it is parsed.
    always_comb begin
        if (first_byte) begin
            pos_cur   = '0;
            phase_cur = omfsne_pkg::PH_TYPE;
            kind_cur  = '0;
            len_cur   = '0;
            off_cur   = '0;
            class_cur = '0;
            rem_cur   = '0;
            any_cur   = 1'b0;
            stop_cur  = 1'b0;
        end else begin
            pos_cur   = pos_reg;
            phase_cur = phase_reg;
            kind_cur  = kind_reg;
            len_cur   = len_reg;
            off_cur   = off_reg;
            class_cur = class_reg;
            rem_cur   = rem_reg;
            any_cur   = any_reg;
            stop_cur  = stop_reg;
        end
    end

    assign in_file  = pos_cur < stream_length;
    assign active   = in_file && !stop_cur;
    assign emit     = active && (phase_cur == omfsne_pkg::PH_NAME);
    assign len_full = {data_byte, len_cur[7:0]};
    assign name_end = {1'b0, off_cur} + 17'd1 + {9'd0, data_byte};
    assign off_inc  = {1'b0, off_cur} + 17'd1;

    always_comb begin
        if (kind_cur == omfsne_pkg::REC_THEADR) begin
            origin = omfsne_pkg::ORIGIN_HEADER;
        end else if (class_cur == omfsne_pkg::CLASS_DEP_LIST
                     || class_cur == omfsne_pkg::CLASS_DEP_LIST_ALT) begin
            origin = omfsne_pkg::ORIGIN_DEP_LIST;
        end else if (class_cur == omfsne_pkg::CLASS_DEP_FILE) begin
            origin = omfsne_pkg::ORIGIN_DEP_FILE;
        end else begin
            origin = omfsne_pkg::ORIGIN_SRC_FILE;
        end
    end

    // Next state.
    always_comb begin
        phase_next = phase_cur;
        kind_next  = kind_cur;
        len_next   = len_cur;
        off_next   = off_cur;
        class_next = class_cur;
        rem_next   = rem_cur;
        any_next   = any_cur;
        stop_next  = stop_cur;
        pos_next   = (pos_cur != '1) ? pos_cur + 32'd1 : pos_cur;

        if (active) begin
            unique case (phase_cur)
                omfsne_pkg::PH_TYPE: begin
                    if ({1'b0, pos_cur} + 33'd3 > {1'b0, stream_length}) begin
                        stop_next = 1'b1;
                    end else begin
                        kind_next  = data_byte;
                        phase_next = omfsne_pkg::PH_LEN_LO;
                    end
                end
                omfsne_pkg::PH_LEN_LO: begin
                    len_next   = {8'd0, data_byte};
                    phase_next = omfsne_pkg::PH_LEN_HI;
                end
                omfsne_pkg::PH_LEN_HI: begin
                    len_next   = len_full;
                    off_next   = '0;
                    class_next = '0;
                    if ({1'b0, pos_cur} + 33'd1 + {17'd0, len_full}
                        > {1'b0, stream_length}) begin
                        stop_next = 1'b1;
                    end else if (len_full == '0) begin
                        phase_next = omfsne_pkg::PH_TYPE;
                    end else if (kind_cur == omfsne_pkg::REC_THEADR) begin
                        phase_next = omfsne_pkg::PH_HDR_LEN;
                    end else if (kind_cur == omfsne_pkg::REC_COMENT
                                 && len_full >= omfsne_pkg::MIN_LEN_COMENT) begin
                        phase_next = omfsne_pkg::PH_CM_TYPE;
                    end else begin
                        phase_next = omfsne_pkg::PH_SKIP;
                    end
                end
                omfsne_pkg::PH_HDR_LEN, omfsne_pkg::PH_ONE_LEN: begin
                    if (data_byte != '0 && name_end <= {1'b0, len_cur}) begin
                        rem_next   = data_byte;
                        phase_next = omfsne_pkg::PH_NAME;
                    end else begin
                        phase_next = omfsne_pkg::PH_SKIP;
                    end
                end
                omfsne_pkg::PH_CM_TYPE: begin
                    phase_next = omfsne_pkg::PH_CM_CLASS;
                end
                omfsne_pkg::PH_CM_CLASS: begin
                    class_next = data_byte;
                    if ((data_byte == omfsne_pkg::CLASS_DEP_LIST
                         || data_byte == omfsne_pkg::CLASS_DEP_LIST_ALT)
                        && len_cur >= omfsne_pkg::MIN_LEN_DEP_LIST) begin
                        phase_next = omfsne_pkg::PH_STAMP;
                    end else if (data_byte == omfsne_pkg::CLASS_DEP_FILE
                                 && len_cur >= omfsne_pkg::MIN_LEN_DEP_FILE) begin
                        phase_next = omfsne_pkg::PH_STAMP;
                    end else if (data_byte == omfsne_pkg::CLASS_SRC_FILE
                                 && len_cur >= omfsne_pkg::MIN_LEN_SRC_FILE) begin
                        phase_next = omfsne_pkg::PH_ONE_LEN;
                    end else begin
                        phase_next = omfsne_pkg::PH_SKIP;
                    end
                end
                omfsne_pkg::PH_STAMP: begin
                    if (off_cur >= omfsne_pkg::STAMP_LAST_OFFSET) begin
                        phase_next = (class_cur == omfsne_pkg::CLASS_DEP_FILE)
                                     ? omfsne_pkg::PH_ONE_LEN
                                     : omfsne_pkg::PH_LIST_LEN;
                    end
                end
                omfsne_pkg::PH_LIST_LEN: begin
                    // A zero length in a list is passed over.
                    if (data_byte != '0) begin
                        if (name_end > {1'b0, len_cur}) begin
                            phase_next = omfsne_pkg::PH_SKIP;
                        end else begin
                            rem_next   = data_byte;
                            phase_next = omfsne_pkg::PH_NAME;
                        end
                    end
                end
                omfsne_pkg::PH_NAME: begin
                    any_next = 1'b1;
                    rem_next = (rem_cur != '0) ? rem_cur - 8'd1 : rem_cur;
                    if (rem_cur <= 8'd1) begin
                        phase_next = (origin == omfsne_pkg::ORIGIN_DEP_LIST)
                                     ? omfsne_pkg::PH_LIST_LEN
                                     : omfsne_pkg::PH_SKIP;
                    end
                end
                default: begin
                    phase_next = omfsne_pkg::PH_SKIP;
                end
            endcase

            // Every body byte moves the offset; the record end wins over the phase.
            if (phase_cur != omfsne_pkg::PH_TYPE && phase_cur != omfsne_pkg::PH_LEN_LO
                && phase_cur != omfsne_pkg::PH_LEN_HI) begin
                off_next = off_inc[15:0];
                if (off_inc >= {1'b0, len_cur}) begin
                    phase_next = omfsne_pkg::PH_TYPE;
                end
            end
        end
    end

    // Result for the current byte.
    always_comb begin
        result.name_valid  = emit;
        result.name_byte   = emit ? data_byte : 8'd0;
        result.name_last   = emit && (rem_cur <= 8'd1);
        result.name_origin = emit ? origin : omfsne_pkg::ORIGIN_HEADER;
        result.finished    = in_file && ({1'b0, pos_cur} + 33'd1 == {1'b0, stream_length});
        result.found_any   = result.finished && (any_cur || emit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= omfsne_pkg::PH_TYPE;
            kind_reg  <= '0;
            len_reg   <= '0;
            off_reg   <= '0;
            class_reg <= '0;
            rem_reg   <= '0;
            any_reg   <= 1'b0;
            stop_reg  <= 1'b0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            len_reg   <= len_next;
            off_reg   <= off_next;
            class_reg <= class_next;
            rem_reg   <= rem_next;
            any_reg   <= any_next;
            stop_reg  <= stop_next;
        end
    end

`ifndef SYNTH
    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_reg && !(advance && first_byte) |=> stop_reg)
        else $error("parsing restarted without a first byte");

    a_name_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == omfsne_pkg::PH_NAME |-> rem_reg != 8'd0)
        else $error("name phase with no bytes left");

    a_name_in_record: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == omfsne_pkg::PH_NAME |-> off_reg < len_reg)
        else $error("name phase past the record end");
`endif

endmodule

### rtl/core/omf_source_name_extractor.sv
// Object file name extractor. Feed the file one byte per item on the s_ channel,
// with s_tuser set on the first byte of each file; stream_length must be written
// on the cfg_ channel beforehand, while the block is idle. Every input item gives
// exactly one result item on the m_ channel, carrying the byte when it belongs to a
// name from a THEADR record or a name-bearing COMENT class, a name-end flag on
// tlast, the origin of the name, and on the final byte of the file a finished flag
// with whether any name was seen. The block takes one item per clock cycle and
// stalls only when the m_ side holds back tready; an accepted byte passes from the
// input register through the parse logic into the result register. The
// sustained rate is set by the parser state update between the two registers.
// No clearing pass is needed after reset.
module omf_source_name_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: stream_length.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] first_byte
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] name_byte
    output logic        m_tlast,    // name_last
    output logic [7:0]  m_tuser     // [0] name_valid, [2:1] name_origin,
                                    // [3] finished, [4] found_any, [7:5] zero
);

    logic                 length_reg;
    logic [31:0]          stream_length_reg;
    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_data_reg;
    logic                 in_first_reg;
    logic                 out_valid_reg, out_valid_next;
    omfsne_pkg::result_t  out_reg;
    omfsne_pkg::result_t  result;
    logic                 advance;
    logic                 s_accept;

    assign length_reg = 1'b1;
    assign cfg_ready  = length_reg;

    // The byte in the input register moves on whenever the result register
    // is free or is being emptied in the same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_length_reg <= '0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                stream_length_reg <= cfg_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    omfsne_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .data_byte     (in_data_reg),
        .first_byte    (in_first_reg),
        .stream_length (stream_length_reg),
        .result        (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.name_byte;
    assign m_tlast  = out_reg.name_last;
    assign m_tuser  = {3'b000, out_reg.found_any, out_reg.finished,
                       out_reg.name_origin, out_reg.name_valid};

`ifndef SYNTH
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while both stages are full");

    a_last_is_name: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("name end flag on a byte that is not a name");

    a_found_needs_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[4] |-> m_tuser[3])
        else $error("found flag outside the final byte");
`endif

endmodule

### tb/omf_source_name_extractor_tb.sv
module omf_source_name_extractor_tb;
    import omfsne_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int TARGET_ITEMS   = 824;

    typedef enum int {
        LEN_EXACT,
        LEN_SHORT,
        LEN_TRAILING,
        LEN_ZERO,
        LEN_MAX,
        LEN_RANDOM
    } length_mode_t;

    // Tracks the parser state of the block, predicts one result per accepted
    // byte and checks the results that come back, in order.
    class name_checker;
        logic [31:0] file_length;
        logic [31:0] position;
        phase_t      phase;
        logic [7:0]  kind;
        logic [15:0] rec_len;
        logic [15:0] offset;
        logic [7:0]  cm_class;
        logic [7:0]  name_left;
        logic        seen_name;
        logic        halted;
        result_t     expected_names[$];
        int          mismatches;
        int          results_seen;

        function new();
            file_length  = '0;
            mismatches   = 0;
            results_seen = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            position  = '0;
            phase     = PH_TYPE;
            kind      = '0;
            rec_len   = '0;
            offset    = '0;
            cm_class  = '0;
            name_left = '0;
            seen_name = 1'b0;
            halted    = 1'b0;
        endfunction

        function void set_length(logic [31:0] value);
            file_length = value;
        endfunction

        function int pending();
            return expected_names.size();
        endfunction

        function void note_byte(logic [7:0] b, logic first);
            result_t          r;
            origin_t          origin;
            logic             valid;
            logic             last;
            logic             fin;
            logic             in_body;
            logic [16:0]      name_end;
            longint unsigned  pos;
            longint unsigned  len;
            valid   = 1'b0;
            last    = 1'b0;
            fin     = 1'b0;
            in_body = 1'b0;
            origin  = ORIGIN_HEADER;
            if (first) clear_parser();
            pos = position;
            len = file_length;
            if (pos < len) begin
                if (!halted) begin
                    case (phase)
                        PH_TYPE: begin
                            // A type byte needs its two length bytes inside the file.
                            if (pos + 64'd3 > len) begin
                                halted = 1'b1;
                            end else begin
                                kind  = b;
                                phase = PH_LEN_LO;
                            end
                        end
                        PH_LEN_LO: begin
                            rec_len = {8'h00, b};
                            phase   = PH_LEN_HI;
                        end
                        PH_LEN_HI: begin
                            rec_len  = {b, rec_len[7:0]};
                            offset   = '0;
                            cm_class = '0;
                            if (pos + 64'd1 + 64'(rec_len) > len) begin
                                halted = 1'b1;
                            end else if (rec_len == 16'd0) begin
                                phase = PH_TYPE;
                            end else if (kind == REC_THEADR) begin
                                phase = PH_HDR_LEN;
                            end else if (kind == REC_COMENT && rec_len >= MIN_LEN_COMENT) begin
                                phase = PH_CM_TYPE;
                            end else begin
                                phase = PH_SKIP;
                            end
                        end
                        default: begin
                            in_body = 1'b1;
                            case (phase)
                                PH_HDR_LEN, PH_ONE_LEN: begin
                                    name_end = {1'b0, offset} + 17'd1 + {9'd0, b};
                                    if (b != 8'd0 && name_end <= {1'b0, rec_len}) begin
                                        name_left = b;
                                        phase     = PH_NAME;
                                    end else begin
                                        phase = PH_SKIP;
                                    end
                                end
                                PH_CM_TYPE: phase = PH_CM_CLASS;
                                PH_CM_CLASS: begin
                                    cm_class = b;
                                    if ((b == CLASS_DEP_LIST || b == CLASS_DEP_LIST_ALT)
                                            && rec_len >= MIN_LEN_DEP_LIST)
                                        phase = PH_STAMP;
                                    else if (b == CLASS_DEP_FILE && rec_len >= MIN_LEN_DEP_FILE)
                                        phase = PH_STAMP;
                                    else if (b == CLASS_SRC_FILE && rec_len >= MIN_LEN_SRC_FILE)
                                        phase = PH_ONE_LEN;
                                    else
                                        phase = PH_SKIP;
                                end
                                PH_STAMP: begin
                                    if (offset >= STAMP_LAST_OFFSET) begin
                                        if (cm_class == CLASS_DEP_FILE) phase = PH_ONE_LEN;
                                        else phase = PH_LIST_LEN;
                                    end
                                end
                                PH_LIST_LEN: begin
                                    // A zero length in a list is skipped silently.
                                    if (b != 8'd0) begin
                                        name_end = {1'b0, offset} + 17'd1 + {9'd0, b};
                                        if (name_end > {1'b0, rec_len}) begin
                                            phase = PH_SKIP;
                                        end else begin
                                            name_left = b;
                                            phase     = PH_NAME;
                                        end
                                    end
                                end
                                PH_NAME: begin
                                    valid = 1'b1;
                                    if (kind == REC_THEADR)
                                        origin = ORIGIN_HEADER;
                                    else if (cm_class == CLASS_DEP_LIST
                                            || cm_class == CLASS_DEP_LIST_ALT)
                                        origin = ORIGIN_DEP_LIST;
                                    else if (cm_class == CLASS_DEP_FILE)
                                        origin = ORIGIN_DEP_FILE;
                                    else
                                        origin = ORIGIN_SRC_FILE;
                                    seen_name = 1'b1;
                                    if (name_left > 8'd0) name_left = name_left - 8'd1;
                                    if (name_left == 8'd0) begin
                                        last = 1'b1;
                                        if (origin == ORIGIN_DEP_LIST) phase = PH_LIST_LEN;
                                        else phase = PH_SKIP;
                                    end
                                end
                                default: phase = PH_SKIP;
                            endcase
                        end
                    endcase
                    if (in_body) begin
                        offset = offset + 16'd1;
                        if (offset >= rec_len) phase = PH_TYPE;
                    end
                end
                if (pos + 64'd1 == len) fin = 1'b1;
            end
            if (position != '1) position = position + 32'd1;

            r.name_byte   = valid ? b : 8'h00;
            r.name_valid  = valid;
            r.name_last   = last;
            r.name_origin = valid ? origin : ORIGIN_HEADER;
            r.finished    = fin;
            r.found_any   = fin && seen_name;
            expected_names.push_back(r);
        endfunction

        function string describe(result_t r);
            return $sformatf("byte=%02h valid=%0d last=%0d origin=%0d finished=%0d found=%0d",
                             r.name_byte, r.name_valid, r.name_last, r.name_origin,
                             r.finished, r.found_any);
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (expected_names.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected: %s",
                             results_seen, describe(got));
                return;
            end
            want = expected_names.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch on result %0d", results_seen);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [7:0]  m_tuser;

    name_checker names = new();
    logic [7:0]  file_bytes[$];
    bit          steady_sender = 1'b0;
    bit          hold_request  = 1'b0;
    int          items_sent    = 0;
    int          quiet_cycles  = 0;

    omf_source_name_extractor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // A length byte and the name; mostly short names, a few empty or long ones.
    function automatic void add_name(ref logic [7:0] body[$]);
        int n;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) n = 0;
        else if (roll < 9) n = $urandom_range(64, 255);
        else n = $urandom_range(1, 8);
        body.push_back(8'(n));
        repeat (n) body.push_back(any_byte());
    endfunction

    // Appends one record to the file. Most are well formed name carriers; the
    // declared length is sometimes cut short (short records, names that do not
    // fit) or padded, and a few records are foreign types or empty.
    function automatic void add_record();
        logic [7:0]  body[$];
        logic [7:0]  kind;
        logic [15:0] rec_len;
        int          pick;
        pick = $urandom_range(0, 39);
        kind = REC_COMENT;
        if (pick < 9) begin
            kind = REC_THEADR;
            add_name(body);
        end else if (pick < 17) begin
            body.push_back(any_byte());
            body.push_back(($urandom_range(0, 1) == 0) ? CLASS_DEP_LIST : CLASS_DEP_LIST_ALT);
            repeat (4) body.push_back(any_byte());
            repeat ($urandom_range(0, 4)) add_name(body);
        end else if (pick < 22) begin
            body.push_back(any_byte());
            body.push_back(CLASS_DEP_FILE);
            repeat (4) body.push_back(any_byte());
            add_name(body);
        end else if (pick < 27) begin
            body.push_back(any_byte());
            body.push_back(CLASS_SRC_FILE);
            add_name(body);
        end else if (pick < 31) begin
            body.push_back(any_byte());
            body.push_back(any_byte());
            repeat ($urandom_range(0, 4)) body.push_back(any_byte());
        end else if (pick < 37) begin
            kind = any_byte();
            repeat ($urandom_range(0, 6)) body.push_back(any_byte());
        end else if (pick < 39) begin
            kind = ($urandom_range(0, 1) == 0) ? REC_THEADR : REC_COMENT;
        end else begin
            // Long record, so that the high length byte is nonzero.
            kind = any_byte();
            repeat ($urandom_range(256, 270)) body.push_back(any_byte());
        end
        rec_len = 16'(body.size());
        case ($urandom_range(0, 9))
            0: if (rec_len > 16'd0) rec_len = 16'($urandom_range(0, rec_len - 1));
            1: rec_len = rec_len + 16'($urandom_range(1, 3));
            default: ;
        endcase
        file_bytes.push_back(kind);
        file_bytes.push_back(rec_len[7:0]);
        file_bytes.push_back(rec_len[15:8]);
        for (int i = 0; i < int'(rec_len); i++)
            file_bytes.push_back((i < body.size()) ? body[i] : any_byte());
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic load_length(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        names.set_length(value);
    endtask

    // Every byte gives one result, so an empty expectation queue means the
    // block is idle. The first edge makes sure the monitor has queued the last
    // accepted byte; the DRAIN_CYCLES wait after it covers its two-stage pipeline.
    task automatic wait_for_drain();
        @(posedge aclk);
        while (names.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_opening_files();
        logic [7:0] header_file [22];
        // A header name holding the extreme byte values, a source file name,
        // then a dependency list record that runs past the end of the file.
        // Two bytes follow beyond the file end.
        header_file = '{REC_THEADR, 8'h03, 8'h00, 8'h02, 8'h00, 8'hFF,
                        REC_COMENT, 8'h04, 8'h00, 8'h00, CLASS_SRC_FILE, 8'h01, 8'h5A,
                        REC_COMENT, 8'h09, 8'h00, 8'h00, CLASS_DEP_LIST,
                        8'h11, 8'h22, 8'h33, 8'h44};
        load_length(32'd20);
        foreach (header_file[i]) push_byte(header_file[i], i == 0);
        s_tvalid <= 1'b0;
        wait_for_drain();
        // Two-byte file: the type byte has no room for its length.
        load_length(32'd2);
        push_byte(REC_THEADR, 1'b1);
        push_byte(8'h00, 1'b0);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_random_file(input int phase_no);
        length_mode_t mode;
        logic [31:0]  length_value;
        int           records;
        int           trailing;
        int           roll;
        bit           fresh;
        bit           squeeze;
        squeeze = (phase_no == 2 || phase_no == 11);
        file_bytes.delete();
        records = squeeze ? 8 : $urandom_range(1, 5);
        repeat (records) add_record();

        roll = $urandom_range(0, 19);
        if (phase_no == 1) mode = LEN_MAX;
        else if (phase_no == 4) mode = LEN_ZERO;
        else if (roll < 12) mode = LEN_EXACT;
        else if (roll < 14) mode = LEN_SHORT;
        else if (roll < 17) mode = LEN_TRAILING;
        else if (roll == 17) mode = LEN_ZERO;
        else if (roll == 18) mode = LEN_MAX;
        else mode = LEN_RANDOM;

        trailing = 0;
        case (mode)
            LEN_EXACT:    length_value = 32'(file_bytes.size());
            LEN_SHORT:    length_value = 32'(file_bytes.size()
                              - $urandom_range(1, (file_bytes.size() > 4) ? 4 : 1));
            LEN_TRAILING: begin
                length_value = 32'(file_bytes.size());
                trailing     = $urandom_range(1, 4);
            end
            LEN_ZERO:     length_value = '0;
            LEN_MAX:      length_value = '1;
            default:      length_value = $urandom;
        endcase
        repeat (trailing) file_bytes.push_back(any_byte());

        wait_for_drain();
        load_length(length_value);

        // The squeeze phases stream without gaps while the result side holds
        // off, so the pipeline fills and the input has to stall.
        steady_sender = squeeze || ($urandom_range(0, 3) == 0);
        if (squeeze) hold_request = 1'b1;
        fresh = ($urandom_range(0, 9) != 0);
        foreach (file_bytes[i])
            push_byte(file_bytes[i], (i == 0) ? fresh : ($urandom_range(0, 149) == 0));
        s_tvalid <= 1'b0;
    endtask

    // Result side: random ready with gaps, occasional open stretches, and a
    // long hold whenever the stimulus asks for one.
    initial begin : result_sink
        int closed_left;
        int open_left;
        closed_left = 0;
        open_left   = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                closed_left  = HOLD_CYCLES - 1;
                open_left    = 0;
                m_tready <= 1'b0;
            end else if (closed_left > 0) begin
                closed_left--;
                m_tready <= 1'b0;
            end else if (open_left > 0) begin
                open_left--;
                m_tready <= 1'b1;
            end else begin
                closed_left = pick_gap();
                if (closed_left > 0) begin
                    closed_left--;
                    m_tready <= 1'b0;
                end else begin
                    if ($urandom_range(0, 49) == 0) open_left = $urandom_range(20, 60);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Input and result handshakes are handled in one process so that the
    // prediction is always queued before any result for it can be checked.
    always @(posedge aclk) begin : handshake_monitor
        result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) names.note_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                got.name_byte   = m_tdata;
                got.name_valid  = m_tuser[0];
                got.name_last   = m_tlast;
                got.name_origin = origin_t'(m_tuser[2:1]);
                got.finished    = m_tuser[3];
                got.found_any   = m_tuser[4];
                names.check_result(got);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_no;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_opening_files();
        phase_no = 0;
        while (items_sent < TARGET_ITEMS) begin
            send_random_file(phase_no);
            phase_no++;
        end

        wait_for_drain();
        if (names.mismatches == 0 && names.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
